@@ rtl/pbe_pkg.sv @@
package pbe_pkg;

  localparam int MAX_PACKET = 128;
  localparam int MAX_LINE   = 4096;
  localparam int LEN_W      = 8;
  localparam int LINE_CNT_W = $clog2(MAX_LINE);
  localparam int TOTAL_W    = 13;
  localparam int RING_AW    = 8;
  localparam int RING_DEPTH = 1 << RING_AW;
  localparam int Q_AW       = 3;
  localparam int Q_DEPTH    = 1 << Q_AW;
  localparam int MAX_CMDS   = 3;
  localparam int LANE_AW    = 3;
  localparam int WORD_W     = 64;
  localparam int CNT_W      = 4;
  localparam int DATA_W     = 88;

  typedef enum logic {
    PK_REPEAT,
    PK_LITERAL
  } pkt_kind_t;

  typedef enum logic [1:0] {
    FS_EMPTY,
    FS_RUN,
    FS_LIT
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_REP_VAL,
    BS_LIT
  } back_state_t;

  typedef struct packed {
    pkt_kind_t          kind;
    logic [LEN_W-1:0]   len;
    logic [7:0]         value;
    logic               step_end;
    logic               line_end;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                 count;
    cmd_t [MAX_CMDS-1:0]        cmd;
  } push_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } ring_wr_t;

  function automatic cmd_t make_cmd(pkt_kind_t k, logic [LEN_W-1:0] len, logic [7:0] v);
    cmd_t c;
    c.kind     = k;
    c.len      = len;
    c.value    = v;
    c.step_end = 1'b0;
    c.line_end = 1'b0;
    return c;
  endfunction

endpackage

@@ rtl/pbe_front.sv @@
module pbe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_room,
  input  logic              ring_full,
  output pbe_pkg::push_t    push,
  output pbe_pkg::ring_wr_t ring_wr
);

  pbe_pkg::front_state_t                state, state_next;
  logic [7:0]                           run_val, run_val_next;
  logic [pbe_pkg::LEN_W-1:0]            run_len, run_len_next;
  logic [pbe_pkg::LEN_W-1:0]            lit_cnt, lit_cnt_next;
  logic [7:0]                           p1, p1_next, p2, p2_next;
  logic [pbe_pkg::LINE_CNT_W-1:0]       in_count, in_count_next;
  logic                                 accept, last;

  assign in_ready     = q_room && !ring_full;
  assign accept       = in_valid && in_ready;
  assign ring_wr.en   = accept;
  assign ring_wr.data = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pbe_pkg::FS_EMPTY;
      run_len  <= '0;
      lit_cnt  <= '0;
      in_count <= '0;
    end else begin
      state    <= state_next;
      run_len  <= run_len_next;
      lit_cnt  <= lit_cnt_next;
      in_count <= in_count_next;
    end
    run_val <= run_val_next;
    p1      <= p1_next;
    p2      <= p2_next;
  end

  always_comb begin
    state_next    = state;
    run_val_next  = run_val;
    run_len_next  = run_len;
    lit_cnt_next  = lit_cnt;
    p1_next       = p1;
    p2_next       = p2;
    in_count_next = in_count;
    push          = '0;
    last          = in_last ||
                    (in_count == pbe_pkg::LINE_CNT_W'(pbe_pkg::MAX_LINE - 1));
    if (accept) begin
      in_count_next = last ? '0 : in_count + 1'b1;
      case (state)
        pbe_pkg::FS_EMPTY: begin
          if (last) begin
            push.cmd[0] = pbe_pkg::make_cmd(pbe_pkg::PK_LITERAL, 8'd1, in_byte);
            push.count  = 2'd1;
          end else begin
            state_next   = pbe_pkg::FS_RUN;
            run_val_next = in_byte;
            run_len_next = 8'd1;
          end
        end
        pbe_pkg::FS_RUN: begin
          if (in_byte == run_val) begin
            if (last || run_len == pbe_pkg::LEN_W'(pbe_pkg::MAX_PACKET - 1)) begin
              push.cmd[0] = pbe_pkg::make_cmd(pbe_pkg::PK_REPEAT, run_len + 8'd1, run_val);
              push.count  = 2'd1;
              state_next  = pbe_pkg::FS_EMPTY;
            end else begin
              run_len_next = run_len + 8'd1;
            end
          end else if (run_len >= 8'd2) begin
            push.cmd[0] = pbe_pkg::make_cmd(pbe_pkg::PK_REPEAT, run_len, run_val);
            push.count  = 2'd1;
            if (last) begin
              push.cmd[1] = pbe_pkg::make_cmd(pbe_pkg::PK_LITERAL, 8'd1, in_byte);
              push.count  = 2'd2;
              state_next  = pbe_pkg::FS_EMPTY;
            end else begin
              run_val_next = in_byte;
              run_len_next = 8'd1;
            end
          end else begin
            if (last) begin
              push.cmd[0] = pbe_pkg::make_cmd(pbe_pkg::PK_LITERAL, 8'd1, run_val);
              push.cmd[1] = pbe_pkg::make_cmd(pbe_pkg::PK_LITERAL, 8'd1, in_byte);
              push.count  = 2'd2;
              state_next  = pbe_pkg::FS_EMPTY;
            end else begin
              state_next   = pbe_pkg::FS_LIT;
              lit_cnt_next = 8'd2;
              p2_next      = run_val;
              p1_next      = in_byte;
            end
          end
        end
        pbe_pkg::FS_LIT: begin
          if (p1 == in_byte && p2 == in_byte) begin
            push.cmd[0] = pbe_pkg::make_cmd(pbe_pkg::PK_LITERAL, lit_cnt - 8'd2, in_byte);
            push.count  = 2'd1;
            if (last) begin
              push.cmd[1] = pbe_pkg::make_cmd(pbe_pkg::PK_REPEAT, 8'd3, in_byte);
              push.count  = 2'd2;
              state_next  = pbe_pkg::FS_EMPTY;
            end else begin
              state_next   = pbe_pkg::FS_RUN;
              run_val_next = in_byte;
              run_len_next = 8'd3;
            end
          end else if (lit_cnt == pbe_pkg::LEN_W'(pbe_pkg::MAX_PACKET + 1)) begin
            push.cmd[0] = pbe_pkg::make_cmd(pbe_pkg::PK_LITERAL,
                                            pbe_pkg::LEN_W'(pbe_pkg::MAX_PACKET), in_byte);
            push.count  = 2'd1;
            if (p1 == in_byte) begin
              if (last) begin
                push.cmd[1] = pbe_pkg::make_cmd(pbe_pkg::PK_REPEAT, 8'd2, in_byte);
                push.count  = 2'd2;
                state_next  = pbe_pkg::FS_EMPTY;
              end else begin
                state_next   = pbe_pkg::FS_RUN;
                run_val_next = in_byte;
                run_len_next = 8'd2;
              end
            end else if (last) begin
              push.cmd[1] = pbe_pkg::make_cmd(pbe_pkg::PK_LITERAL, 8'd1, p1);
              push.cmd[2] = pbe_pkg::make_cmd(pbe_pkg::PK_LITERAL, 8'd1, in_byte);
              push.count  = 2'd3;
              state_next  = pbe_pkg::FS_EMPTY;
            end else begin
              lit_cnt_next = 8'd2;
              p2_next      = p1;
              p1_next      = in_byte;
            end
          end else if (last) begin
            push.cmd[0] = pbe_pkg::make_cmd(pbe_pkg::PK_LITERAL, lit_cnt, in_byte);
            push.cmd[1] = pbe_pkg::make_cmd(pbe_pkg::PK_LITERAL, 8'd1, in_byte);
            push.count  = 2'd2;
            state_next  = pbe_pkg::FS_EMPTY;
          end else begin
            lit_cnt_next = lit_cnt + 8'd1;
            p2_next      = p1;
            p1_next      = in_byte;
          end
        end
        default: begin
          state_next = pbe_pkg::FS_EMPTY;
        end
      endcase
      for (int i = 0; i < pbe_pkg::MAX_CMDS; i++) begin
        if (2'(i + 1) == push.count) begin
          push.cmd[i].step_end = 1'b1;
          push.cmd[i].line_end = last;
        end
      end
    end
  end

endmodule

@@ rtl/pbe_cmd_fifo.sv @@
module pbe_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  pbe_pkg::push_t push,
  input  logic           pop,
  output pbe_pkg::cmd_t  head,
  output logic           empty,
  output logic           room
);

  pbe_pkg::cmd_t               mem [pbe_pkg::Q_DEPTH];
  logic [pbe_pkg::Q_AW-1:0]    wr_ptr, rd_ptr;
  logic [pbe_pkg::Q_AW:0]      count;

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);
  assign room  = (count <= (pbe_pkg::Q_AW + 1)'(pbe_pkg::Q_DEPTH - pbe_pkg::MAX_CMDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + pbe_pkg::Q_AW'(push.count);
      rd_ptr <= rd_ptr + pbe_pkg::Q_AW'(pop);
      count  <= count + (pbe_pkg::Q_AW + 1)'(push.count) - (pbe_pkg::Q_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    logic [pbe_pkg::Q_AW-1:0] offs;
    for (int i = 0; i < pbe_pkg::Q_DEPTH; i++) begin
      offs = pbe_pkg::Q_AW'(i) - wr_ptr;
      if (offs < pbe_pkg::Q_AW'(push.count)) begin
        mem[i] <= push.cmd[offs[1:0]];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command queue popped while empty");
  assert property (@(posedge clk) disable iff (rst) (push.count != 2'd0) |-> room)
    else $error("command queue pushed without room");

endmodule

@@ rtl/pbe_back.sv @@
module pbe_back (
  input  logic                          clk,
  input  logic                          rst,
  input  pbe_pkg::ring_wr_t             ring_wr,
  output logic                          ring_full,
  input  pbe_pkg::cmd_t                 head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pbe_pkg::WORD_W-1:0]    out_word,
  output logic [pbe_pkg::CNT_W-1:0]     out_count,
  output logic                          out_last,
  output logic [pbe_pkg::TOTAL_W-1:0]   line_length
);

  logic [7:0]                       ring [pbe_pkg::RING_DEPTH];
  logic [7:0]                       rd_data;
  logic [pbe_pkg::RING_AW-1:0]      wr_ptr, rd_ptr, rd_ptr_next;
  logic [pbe_pkg::RING_AW:0]        used, freed;
  pbe_pkg::back_state_t             state, state_next;
  logic [pbe_pkg::LEN_W-1:0]        lit_left, lit_left_next;
  logic [pbe_pkg::WORD_W-1:0]       acc, word_in;
  logic [pbe_pkg::LANE_AW-1:0]      acc_cnt;
  logic [pbe_pkg::TOTAL_W-1:0]      total, total_inc;
  logic                             can_emit, byte_v, byte_fin, byte_line, flush;
  logic [7:0]                       byte_d;

  assign ring_full = (used == (pbe_pkg::RING_AW + 1)'(pbe_pkg::RING_DEPTH));
  assign can_emit  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (ring_wr.en) begin
      ring[wr_ptr] <= ring_wr.data;
    end
    rd_data <= ring[rd_ptr_next];
  end

  always_comb begin
    state_next    = state;
    lit_left_next = lit_left;
    rd_ptr_next   = rd_ptr;
    freed         = '0;
    pop           = 1'b0;
    byte_v        = 1'b0;
    byte_d        = '0;
    byte_fin      = 1'b0;
    byte_line     = 1'b0;
    case (state)
      pbe_pkg::BS_IDLE: begin
        if (!empty && can_emit) begin
          byte_v        = 1'b1;
          lit_left_next = head.len;
          if (head.kind == pbe_pkg::PK_REPEAT) begin
            byte_d     = 8'd1 - head.len;
            state_next = pbe_pkg::BS_REP_VAL;
          end else begin
            byte_d     = head.len - 8'd1;
            state_next = pbe_pkg::BS_LIT;
          end
        end
      end
      pbe_pkg::BS_REP_VAL: begin
        if (can_emit) begin
          byte_v      = 1'b1;
          byte_d      = head.value;
          byte_fin    = head.step_end;
          byte_line   = head.step_end && head.line_end;
          pop         = 1'b1;
          rd_ptr_next = rd_ptr + pbe_pkg::RING_AW'(head.len);
          freed       = (pbe_pkg::RING_AW + 1)'(head.len);
          state_next  = pbe_pkg::BS_IDLE;
        end
      end
      pbe_pkg::BS_LIT: begin
        if (can_emit) begin
          byte_v        = 1'b1;
          byte_d        = rd_data;
          rd_ptr_next   = rd_ptr + 1'b1;
          freed         = 9'd1;
          lit_left_next = lit_left - 8'd1;
          if (lit_left == 8'd1) begin
            byte_fin   = head.step_end;
            byte_line  = head.step_end && head.line_end;
            pop        = 1'b1;
            state_next = pbe_pkg::BS_IDLE;
          end
        end
      end
      default: begin
        state_next = pbe_pkg::BS_IDLE;
      end
    endcase
  end

  assign word_in   = acc | (pbe_pkg::WORD_W'(byte_d) << {acc_cnt, 3'b000});
  assign flush     = byte_v && (acc_cnt == 3'd7 || byte_fin);
  assign total_inc = (total == {pbe_pkg::TOTAL_W{1'b1}}) ? total : total + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pbe_pkg::BS_IDLE;
      lit_left  <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      used      <= '0;
      acc       <= '0;
      acc_cnt   <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      lit_left <= lit_left_next;
      wr_ptr   <= wr_ptr + pbe_pkg::RING_AW'(ring_wr.en);
      rd_ptr   <= rd_ptr_next;
      used     <= used + (pbe_pkg::RING_AW + 1)'(ring_wr.en) - freed;
      if (flush) begin
        out_valid <= 1'b1;
        acc       <= '0;
        acc_cnt   <= '0;
        total     <= byte_line ? '0 : total_inc;
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        if (byte_v) begin
          acc     <= word_in;
          acc_cnt <= acc_cnt + 1'b1;
          total   <= total_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flush) begin
      out_word    <= word_in;
      out_count   <= {1'b0, acc_cnt} + 4'd1;
      out_last    <= byte_line;
      line_length <= byte_line ? total_inc : '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == pbe_pkg::BS_LIT) |-> !empty)
    else $error("literal in progress without a queued command");
  assert property (@(posedge clk) disable iff (rst) !(freed > used))
    else $error("ring released more bytes than it holds");
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && out_last) |-> (line_length != '0))
    else $error("final word with zero line length");

endmodule

@@ rtl/packbits_line_encoder.sv @@
// The back end takes a packet's header from the registered command queue once the byte that
// settles it is accepted, then one encoded byte per cycle while the output is not stalled;
// a word is presented on the cycle after its eighth byte or the end of a request.
// Throughput: one input byte per cycle while the 256-byte ring has space and the 8-entry
// command queue has three free slots; output gives one encoded byte per cycle unless stalled.
// Reset: synchronous, active high; clears all control state, ring contents stay undefined.
module packbits_line_encoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // in_byte
  input  logic                        s_axis_tlast,  // in_last
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [pbe_pkg::DATA_W-1:0]  m_axis_tdata,  // out_word, out_count, line_length
  output logic                        m_axis_tlast   // out_last
);

  pbe_pkg::push_t                   push;
  pbe_pkg::ring_wr_t                ring_wr;
  pbe_pkg::cmd_t                    head;
  logic                             empty, pop, room, ring_full;
  logic [pbe_pkg::WORD_W-1:0]       out_word;
  logic [pbe_pkg::CNT_W-1:0]        out_count;
  logic [pbe_pkg::TOTAL_W-1:0]      line_length;

  pbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .q_room    (room),
    .ring_full (ring_full),
    .push      (push),
    .ring_wr   (ring_wr)
  );

  pbe_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .room  (room)
  );

  pbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ring_wr     (ring_wr),
    .ring_full   (ring_full),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_word    (out_word),
    .out_count   (out_count),
    .out_last    (m_axis_tlast),
    .line_length (line_length)
  );

  assign m_axis_tdata = {7'b0, line_length, out_count, out_word};

endmodule
